// ----- hdl/ajss_pkg.sv -----
// shared types and constants of the arm joint setpoint shaper
`timescale 1ns / 1ps
`default_nettype none
package ajss_pkg;

  // arm states, same encoding as the requested_state field
  localparam logic [2:0] ST_DISABLED = 3'd0;
  localparam logic [2:0] ST_ERROR    = 3'd1;
  localparam logic [2:0] ST_HOMING   = 3'd2;
  localparam logic [2:0] ST_GRAVITY  = 3'd3;
  localparam logic [2:0] ST_REPLAY   = 3'd4;
  localparam logic [2:0] ST_KEYMOUSE = 3'd5;

  // item kinds, same encoding as the mode field
  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_STATE = 2'd2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MAX_ANGLE = 3'd0;
  localparam logic [2:0] REG_MIN_ANGLE = 3'd1;
  localparam logic [2:0] REG_HOME_STEP = 3'd2;
  localparam logic [2:0] REG_GEAR      = 3'd3;
  localparam logic [2:0] REG_GEAR_INV  = 3'd4;

  localparam int PAW = 5;

  // gains, unsigned q8.8
  localparam logic [15:0] KP_HOME   = 16'd1280;
  localparam logic [15:0] KD_HOME   = 16'd256;
  localparam logic [15:0] KD_GRAV   = 16'd128;
  localparam logic [15:0] KP_SMOOTH = 16'd1536;
  localparam logic [15:0] KD_SMOOTH = 16'd307;

  // smoothing factors 0.15 and 0.05 in q0.16
  localparam logic signed [16:0] ALPHA_REPLAY   = 17'sd9830;
  localparam logic signed [16:0] ALPHA_KEYMOUSE = 17'sd3277;

  localparam logic signed [31:0] DEADBAND     = 32'sd6;
  localparam logic signed [31:0] NEG_DEADBAND = -32'sd6;
  localparam logic signed [31:0] SAT_MAX      = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN      = 32'sh80000000;

  localparam logic signed [49:0] ROUND_HALF = 50'sd32768;

  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [31:0] max_angle;
    logic signed [31:0] min_angle;
    logic [15:0]        home_step;
    logic [15:0]        gear;
    logic [15:0]        gear_inv;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         joint;
    logic               jvalid;
    logic signed [31:0] value;
    logic signed [31:0] grav;
    logic [2:0]         req;
    logic               last;
  } qitem_t;

endpackage
`default_nettype wire

// ----- hdl/ajss_front.sv -----
// input acceptance and classification of transactions
`timescale 1ns / 1ps
`default_nettype none
module ajss_front #(
  parameter int JOINTS = 6
) (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [2:0]         in_joint,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [31:0] in_gravity_torque,
  input  wire logic [2:0]         in_requested_state,
  input  wire logic               in_last_joint,
  input  wire logic               q_full,
  output logic                    push,
  output ajss_pkg::qitem_t        item
);

  logic jvalid;
  logic keep;

  assign jvalid   = (32'(in_joint) < JOINTS);
  assign in_stall = q_full;

  always_comb begin
    unique case (in_mode)
      ajss_pkg::OP_STORE: keep = jvalid;
      ajss_pkg::OP_STATE: keep = (in_requested_state <= ajss_pkg::ST_KEYMOUSE);
      // an out of range tick still closes the round when it is the last joint
      ajss_pkg::OP_TICK:  keep = jvalid | in_last_joint;
      default:            keep = 1'b0;
    endcase
  end

  assign push = in_valid & ~q_full & keep;

  always_comb begin
    item.op     = in_mode;
    item.joint  = in_joint;
    item.jvalid = jvalid;
    item.value  = in_value;
    item.grav   = in_gravity_torque;
    item.req    = in_requested_state;
    item.last   = in_last_joint;
  end

endmodule
`default_nettype wire

// ----- hdl/ajss_queue.sv -----
// short fifo between the classifier and the execution sequencer
`timescale 1ns / 1ps
`default_nettype none
module ajss_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ajss_pkg::qitem_t push_item,
  output logic                  full,
  input  wire logic             pop,
  output ajss_pkg::qitem_t      head,
  output logic                  head_vld
);

  ajss_pkg::qitem_t               mem_r [ajss_pkg::QDEPTH];
  logic [ajss_pkg::QAW-1:0]       wr_ptr_r;
  logic [ajss_pkg::QAW-1:0]       rd_ptr_r;
  logic [ajss_pkg::QCW-1:0]       count_r;

  assign full     = (count_r == ajss_pkg::QCW'(ajss_pkg::QDEPTH));
  assign head_vld = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a transaction");

endmodule
`default_nettype wire

// ----- hdl/ajss_back.sv -----
// execution sequencer: joint state, shared multiplier and result register
`timescale 1ns / 1ps
`default_nettype none
module ajss_back #(
  parameter int JOINTS = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ajss_pkg::cfg_t     cfg,
  input  wire ajss_pkg::qitem_t   head,
  input  wire logic               head_vld,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_joint_out,
  output logic signed [31:0]      out_motor_position_ref,
  output logic [15:0]             out_stiffness_gain,
  output logic [15:0]             out_damping_gain,
  output logic signed [31:0]      out_torque_feedforward,
  output logic [2:0]              out_arm_state_out
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MQ   = 3'd2;
  localparam logic [2:0] S_MSM  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_MPOS = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]         state_r;
  logic [2:0]         arm_mode_r;
  logic               reached_r;
  logic signed [31:0] filt_r [JOINTS];
  logic signed [31:0] user_r [JOINTS];

  logic [2:0]         md_r;
  logic [2:0]         j_r;
  logic               jv_r;
  logic               last_r;
  logic signed [31:0] val_r;
  logic signed [31:0] grav_r;
  logic signed [31:0] f_r;
  logic signed [31:0] u_r;
  logic signed [32:0] d_r;
  logic signed [31:0] ff_r;
  logic signed [49:0] mul_r;
  logic               hr_r;

  logic               out_valid_r;
  logic [2:0]         joint_o_r;
  logic signed [31:0] pos_o_r;
  logic [15:0]        kp_o_r;
  logic [15:0]        kd_o_r;
  logic signed [31:0] ff_o_r;
  logic [2:0]         arm_o_r;

  logic [JW-1:0]      hidx;
  logic [JW-1:0]      jidx;
  logic               cls_off, cls_home, cls_grav, cls_smooth;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [32:0] f_sx;
  logic signed [32:0] f_abs;
  logic signed [31:0] f_home;
  logic               home_hit;
  logic signed [31:0] u_hi;
  logic signed [31:0] u_clamp;
  logic signed [49:0] rnd_w;
  logic signed [41:0] pos_w;
  logic signed [31:0] pos_sat;
  logic signed [31:0] q_w;
  logic               slot_free;
  logic               fin_go;
  logic               reach_eff;
  logic [2:0]         mode_nxt;
  logic               reached_nxt;
  logic signed [31:0] filt_wr;
  logic signed [31:0] user_wr;
  logic signed [31:0] pos_o_nxt;
  logic [15:0]        kp_o_nxt;
  logic [15:0]        kd_o_nxt;
  logic signed [31:0] ff_o_nxt;

  assign hidx = JW'(head.joint);
  assign jidx = JW'(j_r);
  assign pop  = (state_r == S_IDLE) && head_vld;

  always_comb begin
    cls_off    = 1'b0;
    cls_home   = 1'b0;
    cls_grav   = 1'b0;
    cls_smooth = 1'b0;
    unique case (md_r) inside
      ajss_pkg::ST_DISABLED, ajss_pkg::ST_ERROR:  cls_off    = 1'b1;
      ajss_pkg::ST_HOMING:                        cls_home   = 1'b1;
      ajss_pkg::ST_GRAVITY:                       cls_grav   = 1'b1;
      ajss_pkg::ST_REPLAY, ajss_pkg::ST_KEYMOUSE: cls_smooth = 1'b1;
      default:                                    cls_off    = 1'b1;
    endcase
  end

  // shared 33x17 multiplier, operands picked by the sequencer step
  always_comb begin
    unique case (state_r)
      S_PREP: begin
        mul_a = {grav_r[31], grav_r};
        mul_b = {1'b0, cfg.gear_inv};
      end
      S_MQ: begin
        mul_a = {val_r[31], val_r};
        mul_b = {1'b0, cfg.gear_inv};
      end
      S_MSM: begin
        mul_a = d_r;
        mul_b = (md_r == ajss_pkg::ST_KEYMOUSE) ? ajss_pkg::ALPHA_KEYMOUSE
                                                 : ajss_pkg::ALPHA_REPLAY;
      end
      S_MPOS: begin
        mul_a = {f_r[31], f_r};
        mul_b = {1'b0, cfg.gear};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // homing ramp toward zero with a sign dead band
  always_comb begin
    f_sx     = {f_r[31], f_r};
    f_abs    = f_r[31] ? -f_sx : f_sx;
    home_hit = (f_abs > $signed({17'd0, cfg.home_step}));
    if (!home_hit)                       f_home = '0;
    else if (f_r < ajss_pkg::NEG_DEADBAND) f_home = f_r + $signed({16'd0, cfg.home_step});
    else if (f_r > ajss_pkg::DEADBAND)     f_home = f_r - $signed({16'd0, cfg.home_step});
    else                                 f_home = f_r;
  end

  // max first, then min, so min wins on a crossed pair
  assign u_hi    = (u_r > cfg.max_angle) ? cfg.max_angle : u_r;
  assign u_clamp = (u_hi < cfg.min_angle) ? cfg.min_angle : u_hi;

  assign rnd_w = mul_r + ajss_pkg::ROUND_HALF;
  assign q_w   = mul_r[47:16];
  assign pos_w = mul_r[49:8];

  always_comb begin
    if (pos_w[41:31] == {11{pos_w[31]}}) pos_sat = pos_w[31:0];
    else if (pos_w[41])                  pos_sat = ajss_pkg::SAT_MIN;
    else                                 pos_sat = ajss_pkg::SAT_MAX;
  end

  assign slot_free = ~out_valid_r | ~out_stall;
  assign fin_go    = (state_r == S_FIN) && (slot_free || !jv_r);

  always_comb begin
    reach_eff   = reached_r & ~(jv_r & cls_home & ~hr_r);
    mode_nxt    = arm_mode_r;
    reached_nxt = reach_eff;
    if (last_r) begin
      if ((arm_mode_r == ajss_pkg::ST_HOMING) && reach_eff) mode_nxt = ajss_pkg::ST_GRAVITY;
      reached_nxt = 1'b1;
    end
  end

  always_comb begin
    filt_wr   = (cls_off | cls_grav) ? q_w : f_r;
    user_wr   = (cls_off | cls_grav) ? q_w : (cls_smooth ? u_r : f_r);
    pos_o_nxt = (cls_home | cls_smooth) ? pos_sat : '0;
    ff_o_nxt  = cls_off ? '0 : ff_r;
    kp_o_nxt  = cls_home ? ajss_pkg::KP_HOME : (cls_smooth ? ajss_pkg::KP_SMOOTH : '0);
    kd_o_nxt  = cls_home ? ajss_pkg::KD_HOME :
                cls_grav ? ajss_pkg::KD_GRAV :
                cls_smooth ? ajss_pkg::KD_SMOOTH : '0;
  end

  // control state and joint tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arm_mode_r  <= ajss_pkg::ST_HOMING;
      reached_r   <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        filt_r[i] <= '0;
        user_r[i] <= '0;
      end
    end else begin
      if (fin_go && jv_r)  out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            unique case (head.op)
              ajss_pkg::OP_STORE: user_r[hidx] <= head.value;
              ajss_pkg::OP_STATE: arm_mode_r   <= head.req;
              ajss_pkg::OP_TICK:  state_r      <= head.jvalid ? S_PREP : S_FIN;
              default: ;
            endcase
          end
        end
        S_PREP: state_r <= S_MQ;
        S_MQ: begin
          if (cls_smooth)    state_r <= S_MSM;
          else if (cls_home) state_r <= S_MPOS;
          else               state_r <= S_FIN;
        end
        S_MSM:  state_r <= S_ADD;
        S_ADD:  state_r <= S_MPOS;
        S_MPOS: state_r <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state_r    <= S_IDLE;
            arm_mode_r <= mode_nxt;
            reached_r  <= reached_nxt;
            if (jv_r) begin
              filt_r[jidx] <= filt_wr;
              user_r[jidx] <= user_wr;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r != S_IDLE && state_r != S_FIN) mul_r <= mul_p;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          md_r   <= arm_mode_r;
          j_r    <= head.joint;
          jv_r   <= head.jvalid;
          last_r <= head.last;
          val_r  <= head.value;
          grav_r <= head.grav;
          f_r    <= filt_r[hidx];
          u_r    <= user_r[hidx];
        end
      end
      S_PREP: begin
        if (cls_home) f_r <= f_home;
        hr_r <= ~home_hit;
        u_r  <= u_clamp;
      end
      S_MQ: begin
        ff_r <= mul_r[47:16];
        d_r  <= {u_r[31], u_r} - {f_r[31], f_r};
      end
      S_ADD: f_r <= f_r + rnd_w[47:16];
      default: ;
    endcase
    if (fin_go && jv_r) begin
      joint_o_r <= j_r;
      pos_o_r   <= pos_o_nxt;
      kp_o_r    <= kp_o_nxt;
      kd_o_r    <= kd_o_nxt;
      ff_o_r    <= ff_o_nxt;
      arm_o_r   <= mode_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_joint_out          = joint_o_r;
  assign out_motor_position_ref = pos_o_r;
  assign out_stiffness_gain     = kp_o_r;
  assign out_damping_gain       = kd_o_r;
  assign out_torque_feedforward = ff_o_r;
  assign out_arm_state_out      = arm_o_r;

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && jv_r && !slot_free) |=> state_r == S_FIN)
    else $error("tick finished while the result register was occupied");

  a_mode_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_FIN) |=> $stable(arm_mode_r))
    else $error("arm state changed in the middle of a tick");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && jv_r) |=> out_valid_r)
    else $error("finished tick produced no result");

endmodule
`default_nettype wire

// ----- hdl/arm_joint_setpoint_shaper.sv -----
// top level: configuration registers, classifier, queue and sequencer
// a transaction enters the queue at its accept edge; store and state requests take
//   effect when the sequencer pops them, and a tick result is registered after the steps
//   prep, mq, fin (disabled, error, gravity comp), prep, mq, mpos, fin (homing) or prep,
//   mq, msm, add, mpos, fin (replay, keymouse); ticks run one at a time on the single
//   shared 33x17 multiplier, and the sequencer pops no new item until it is back in idle
// reset (synchronous, rst_n low): homing state, all targets zero, clamps zero,
//   homing step 66, gear ratio 1.0, inverse ratio 65535, queue and result empty
`timescale 1ns / 1ps
`default_nettype none
module arm_joint_setpoint_shaper #(
  parameter int JOINTS = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_mode,
  input  wire logic [2:0]                in_joint,
  input  wire logic signed [31:0]        in_value,
  input  wire logic signed [31:0]        in_gravity_torque,
  input  wire logic [2:0]                in_requested_state,
  input  wire logic                      in_last_joint,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_joint_out,
  output logic signed [31:0]             out_motor_position_ref,
  output logic [15:0]                    out_stiffness_gain,
  output logic [15:0]                    out_damping_gain,
  output logic signed [31:0]             out_torque_feedforward,
  output logic [2:0]                     out_arm_state_out,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ajss_pkg::PAW-1:0]  paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  ajss_pkg::cfg_t   cfg_r;
  ajss_pkg::qitem_t push_item;
  ajss_pkg::qitem_t head;
  logic             push;
  logic             q_full;
  logic             pop;
  logic             head_vld;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_angle <= '0;
      cfg_r.min_angle <= '0;
      cfg_r.home_step <= 16'd66;
      cfg_r.gear      <= 16'd256;
      cfg_r.gear_inv  <= 16'hffff;
    end else if (wr_en) begin
      unique case (reg_idx)
        ajss_pkg::REG_MAX_ANGLE: cfg_r.max_angle <= pwdata;
        ajss_pkg::REG_MIN_ANGLE: cfg_r.min_angle <= pwdata;
        ajss_pkg::REG_HOME_STEP: cfg_r.home_step <= pwdata[15:0];
        ajss_pkg::REG_GEAR:      cfg_r.gear      <= pwdata[15:0];
        ajss_pkg::REG_GEAR_INV:  cfg_r.gear_inv  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ajss_pkg::REG_MAX_ANGLE: prdata = cfg_r.max_angle;
      ajss_pkg::REG_MIN_ANGLE: prdata = cfg_r.min_angle;
      ajss_pkg::REG_HOME_STEP: prdata = {16'd0, cfg_r.home_step};
      ajss_pkg::REG_GEAR:      prdata = {16'd0, cfg_r.gear};
      ajss_pkg::REG_GEAR_INV:  prdata = {16'd0, cfg_r.gear_inv};
      default:                 prdata = '0;
    endcase
  end

  ajss_front #(.JOINTS(JOINTS)) u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_joint           (in_joint),
    .in_value           (in_value),
    .in_gravity_torque  (in_gravity_torque),
    .in_requested_state (in_requested_state),
    .in_last_joint      (in_last_joint),
    .q_full             (q_full),
    .push               (push),
    .item               (push_item)
  );

  ajss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .head_vld  (head_vld)
  );

  ajss_back #(.JOINTS(JOINTS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .head                   (head),
    .head_vld               (head_vld),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_joint_out          (out_joint_out),
    .out_motor_position_ref (out_motor_position_ref),
    .out_stiffness_gain     (out_stiffness_gain),
    .out_damping_gain       (out_damping_gain),
    .out_torque_feedforward (out_torque_feedforward),
    .out_arm_state_out      (out_arm_state_out)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for the arm joint setpoint shaper: directed rows, then random phases
`timescale 1ns / 1ps
module tb;
  import ajss_pkg::*;

  localparam int JOINTS          = 6;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int ITEMS_PER_PHASE = 245;
  localparam int PHASES          = 7;

  // encodings the block has to ignore
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] pos;
    logic [15:0]        kp;
    logic [15:0]        kd;
    logic signed [31:0] ff;
    logic [2:0]         st;
  } joint_cmd_t;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         joint;
    logic signed [31:0] value;
    logic signed [31:0] grav;
    logic [2:0]         req;
    logic               last;
    bit                 typed;
    joint_cmd_t         want;
  } joint_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = '0;
  logic [2:0]           in_joint = '0;
  logic signed [31:0]   in_value = '0;
  logic signed [31:0]   in_gravity_torque = '0;
  logic [2:0]           in_requested_state = '0;
  logic                 in_last_joint = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_joint_out;
  logic signed [31:0]   out_motor_position_ref;
  logic [15:0]          out_stiffness_gain;
  logic [15:0]          out_damping_gain;
  logic signed [31:0]   out_torque_feedforward;
  logic [2:0]           out_arm_state_out;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PAW-1:0]       paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // shadow of the shaper state and its registers
  logic signed [31:0]   filt_tgt [JOINTS];
  logic signed [31:0]   user_tgt [JOINTS];
  logic [2:0]           arm_st;
  bit                   reached;
  logic signed [31:0]   top_angle;
  logic signed [31:0]   bottom_angle;
  logic [15:0]          ramp_step;
  logic [15:0]          gear;
  logic [15:0]          gear_inv;

  joint_cmd_t           cmds_due [$];
  joint_item_t          plan [$];
  logic [31:0]          reg_plan [5];
  int                   mismatches = 0;
  int                   quiet = 0;
  bit                   calm = 1'b0;

  arm_joint_setpoint_shaper #(.JOINTS(JOINTS)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag(input string what, input longint got, input longint want);
    $display("mismatch at %0t ns: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction

  // advances the shadow state by one transaction; returns 1 when a command comes out
  function automatic bit shape_item(input joint_item_t s, output joint_cmd_t cmd);
    longint q, f, u, pos, ff, step, rate;
    bit ok;
    ok = (s.joint < 3'(JOINTS));
    cmd = '0;
    pos = 0;
    ff = 0;
    if (s.mode == OP_STORE) begin
      if (ok) user_tgt[s.joint] = s.value;
      return 1'b0;
    end
    if (s.mode == OP_STATE) begin
      if (s.req <= ST_KEYMOUSE) arm_st = s.req;
      return 1'b0;
    end
    if (s.mode != OP_TICK) return 1'b0;
    if (ok) begin
      q = (longint'(s.value) * longint'(gear_inv)) >>> 16;
      ff = (longint'(s.grav) * longint'(gear_inv)) >>> 16;
      f = longint'(filt_tgt[s.joint]);
      step = longint'(ramp_step);
      case (arm_st)
        ST_DISABLED, ST_ERROR: begin
          user_tgt[s.joint] = q[31:0];
          filt_tgt[s.joint] = q[31:0];
          ff = 0;
        end
        ST_HOMING: begin
          // one step toward zero, but no move inside the sign dead band
          if ((f < 0 ? -f : f) > step) begin
            if (-f > longint'(DEADBAND)) f = f + step;
            else if (-f < longint'(NEG_DEADBAND)) f = f - step;
            reached = 1'b0;
          end else begin
            f = 0;
          end
          filt_tgt[s.joint] = f[31:0];
          user_tgt[s.joint] = f[31:0];
          pos = (longint'(filt_tgt[s.joint]) * longint'(gear)) >>> 8;
          cmd.kp = KP_HOME;
          cmd.kd = KD_HOME;
        end
        ST_GRAVITY: begin
          user_tgt[s.joint] = q[31:0];
          filt_tgt[s.joint] = q[31:0];
          cmd.kd = KD_GRAV;
        end
        default: begin
          // max clamp first, so the min clamp wins when the two cross
          u = longint'(user_tgt[s.joint]);
          if (u > longint'(top_angle)) u = longint'(top_angle);
          if (u < longint'(bottom_angle)) u = longint'(bottom_angle);
          user_tgt[s.joint] = u[31:0];
          rate = (arm_st == ST_KEYMOUSE) ? longint'(ALPHA_KEYMOUSE) : longint'(ALPHA_REPLAY);
          f = f + (((u - f) * rate + longint'(ROUND_HALF)) >>> 16);
          filt_tgt[s.joint] = f[31:0];
          pos = (longint'(filt_tgt[s.joint]) * longint'(gear)) >>> 8;
          cmd.kp = KP_SMOOTH;
          cmd.kd = KD_SMOOTH;
        end
      endcase
    end
    if (s.last) begin
      if (arm_st == ST_HOMING && reached) arm_st = ST_GRAVITY;
      reached = 1'b1;
    end
    cmd.joint = s.joint;
    cmd.pos = sat32(pos);
    cmd.ff = sat32(ff);
    cmd.st = arm_st;
    return ok;
  endfunction

  function automatic joint_item_t mk(input logic [1:0] mode, input logic [2:0] joint,
                                     input logic signed [31:0] value,
                                     input logic signed [31:0] grav, input logic [2:0] req,
                                     input logic last, input bit typed = 1'b0,
                                     input joint_cmd_t want = '0);
    joint_item_t s;
    s.mode = mode;
    s.joint = joint;
    s.value = value;
    s.grav = grav;
    s.req = req;
    s.last = last;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned k;
    int v;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      v = int'($urandom_range(0, 4000)) - 2000;
      return v;
    end
    if (k < 60) begin
      v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      return v;
    end
    if (k < 75) begin
      case ($urandom_range(0, 3))
        0: return SAT_MAX;
        1: return SAT_MIN;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_state();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 4) return ST_UNKNOWN - 3'($urandom_range(0, 1));
    if (k < 9) return ST_DISABLED;
    if (k < 14) return ST_ERROR;
    if (k < 40) return ST_HOMING;
    if (k < 55) return ST_GRAVITY;
    if (k < 78) return ST_REPLAY;
    return ST_KEYMOUSE;
  endfunction

  function automatic void set_plan(input logic [31:0] top, input logic [31:0] bottom,
                                   input logic [15:0] step, input logic [15:0] ratio,
                                   input logic [15:0] ratio_inv);
    reg_plan[REG_MAX_ANGLE] = top;
    reg_plan[REG_MIN_ANGLE] = bottom;
    reg_plan[REG_HOME_STEP] = {16'd0, step};
    reg_plan[REG_GEAR]      = {16'd0, ratio};
    reg_plan[REG_GEAR_INV]  = {16'd0, ratio_inv};
  endfunction

  function automatic void load_reg(input logic [2:0] r, input logic [31:0] d);
    case (r)
      REG_MAX_ANGLE: top_angle = d;
      REG_MIN_ANGLE: bottom_angle = d;
      REG_HOME_STEP: ramp_step = d[15:0];
      REG_GEAR:      gear = d[15:0];
      REG_GEAR_INV:  gear_inv = d[15:0];
      default: ;
    endcase
  endfunction

  // setup then access phase; psel is left high so transfers can run back to back
  task automatic apb_xfer(input bit wr, input logic [2:0] r, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic program_regs();
    logic [31:0] rd;
    for (logic [2:0] r = REG_MAX_ANGLE; r <= REG_GEAR_INV; r++) begin
      apb_xfer(1'b1, r, reg_plan[r], rd);
      load_reg(r, reg_plan[r]);
    end
    for (logic [2:0] r = REG_MAX_ANGLE; r <= REG_GEAR_INV; r++) begin
      apb_xfer(1'b0, r, 32'd0, rd);
      if (rd !== reg_plan[r]) flag("register readback", longint'(rd), longint'(reg_plan[r]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(input joint_item_t s);
    joint_cmd_t cmd;
    if (!calm) begin
      while ($urandom_range(0, 99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mode <= s.mode;
    in_joint <= s.joint;
    in_value <= s.value;
    in_gravity_torque <= s.grav;
    in_requested_state <= s.req;
    in_last_joint <= s.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (shape_item(s, cmd)) cmds_due.push_back(s.typed ? s.want : cmd);
  endtask

  // idle the input, drain the results, then allow for items that produce nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 35);

  always @(posedge clk) begin
    joint_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cmds_due.size() == 0) begin
        flag("unexpected transaction, joint", longint'(out_joint_out), -1);
      end else begin
        want = cmds_due.pop_front();
        if (out_joint_out !== want.joint)
          flag("joint_out", longint'(out_joint_out), longint'(want.joint));
        if (out_motor_position_ref !== want.pos)
          flag("motor_position_ref", longint'(out_motor_position_ref), longint'(want.pos));
        if (out_stiffness_gain !== want.kp)
          flag("stiffness_gain", longint'(out_stiffness_gain), longint'(want.kp));
        if (out_damping_gain !== want.kd)
          flag("damping_gain", longint'(out_damping_gain), longint'(want.kd));
        if (out_torque_feedforward !== want.ff)
          flag("torque_feedforward", longint'(out_torque_feedforward), longint'(want.ff));
        if (out_arm_state_out !== want.st)
          flag("arm_state_out", longint'(out_arm_state_out), longint'(want.st));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int sent;
    for (int j = 0; j < JOINTS; j++) begin
      filt_tgt[j] = '0;
      user_tgt[j] = '0;
    end
    arm_st = ST_HOMING;
    reached = 1'b1;
    set_plan(32'd0, 32'd0, 16'd66, 16'd256, 16'd65535);
    for (logic [2:0] r = REG_MAX_ANGLE; r <= REG_GEAR_INV; r++) load_reg(r, reg_plan[r]);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, reset register values
    plan.push_back(mk(OP_TICK, 3'd0, 32'sd0, 32'sd0, ST_DISABLED, 1'b0, 1'b1,
                      '{3'd0, 32'sd0, KP_HOME, KD_HOME, 32'sd0, ST_HOMING}));
    // every joint already at zero, so the end of the tick leaves homing
    plan.push_back(mk(OP_TICK, 3'd5, 32'sd0, 32'sd0, ST_DISABLED, 1'b1, 1'b1,
                      '{3'd5, 32'sd0, KP_HOME, KD_HOME, 32'sd0, ST_GRAVITY}));
    plan.push_back(mk(OP_TICK, 3'd1, SAT_MAX, SAT_MAX, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd2, SAT_MIN, SAT_MIN, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_STATE, 3'd0, 32'sd0, 32'sd0, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd3, SAT_MAX, SAT_MAX, ST_DISABLED, 1'b0, 1'b1,
                      '{3'd3, 32'sd0, 16'd0, 16'd0, 32'sd0, ST_DISABLED}));
    plan.push_back(mk(OP_STATE, 3'd0, 32'sd0, 32'sd0, ST_ERROR, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd4, SAT_MIN, SAT_MIN, ST_DISABLED, 1'b1, 1'b1,
                      '{3'd4, 32'sd0, 16'd0, 16'd0, 32'sd0, ST_ERROR}));
    plan.push_back(mk(OP_STATE, 3'd7, -32'sd1, -32'sd1, ST_UNKNOWN, 1'b1));
    plan.push_back(mk(OP_UNUSED, 3'd0, -32'sd1, -32'sd1, ST_HOMING, 1'b1));
    plan.push_back(mk(OP_TICK, 3'd6, 32'sd100, 32'sd100, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_STORE, 3'd7, -32'sd1, 32'sd0, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_STORE, 3'd0, SAT_MAX, 32'sd0, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_STORE, 3'd1, SAT_MIN, 32'sd0, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_STATE, 3'd0, 32'sd0, 32'sd0, ST_REPLAY, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd0, 32'sh12345, -32'sd77, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd1, -32'sd1, 32'sd1, ST_DISABLED, 1'b0));
    plan.push_back(mk(OP_STATE, 3'd0, 32'sd0, 32'sd0, ST_KEYMOUSE, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd0, -32'sd1, -32'sd1, ST_DISABLED, 1'b1));
    plan.push_back(mk(OP_STATE, 3'd0, 32'sd0, 32'sd0, ST_HOMING, 1'b0));
    plan.push_back(mk(OP_TICK, 3'd3, SAT_MAX, 32'sd5, ST_DISABLED, 1'b0));
    // out-of-range joint still closes the tick
    plan.push_back(mk(OP_TICK, 3'd7, 32'sd0, 32'sd0, ST_DISABLED, 1'b1));
    plan.push_back(mk(OP_TICK, 3'd0, 32'sd0, 32'sd0, ST_DISABLED, 1'b1));
    plan.push_back(mk(OP_STATE, 3'd0, 32'sd0, 32'sd0, ST_UNKNOWN - 3'd1, 1'b0));
    foreach (plan[i]) send_item(plan[i]);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 1);
      case (ph)
        0: set_plan(32'h7fffffff, 32'h80000000, 16'd65535, 16'd65535, 16'd65535);
        1: set_plan($urandom_range(0, 1 << 18), -$urandom_range(0, 1 << 18),
                    16'($urandom_range(100, 4000)), 16'd256, 16'd65535);
        2: set_plan(-32'sd1000, 32'sd5000, 16'd0, 16'd1, 16'd1);
        3: set_plan($urandom, $urandom, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        4: set_plan(32'sd262144, -32'sd262144, 16'd66, 16'd256, 16'd65535);
        5: set_plan($urandom_range(0, 1 << 20), -$urandom_range(0, 1 << 20),
                    16'($urandom_range(1, 6)), 16'($urandom_range(1, 65535)),
                    16'($urandom_range(1, 65535)));
        default: set_plan(32'h80000000, 32'h7fffffff, 16'd1, 16'd65535, 16'd1);
      endcase
      program_regs();
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 12) begin
          send_item(mk(OP_STATE, 3'($urandom_range(0, 7)), pick_value(), pick_value(),
                       pick_state(), 1'($urandom_range(0, 1))));
          sent++;
        end
        // one control period: joints in order, the last one flagged, now and then broken
        for (int j = 0; j < JOINTS; j++) begin
          if ($urandom_range(0, 99) < 15) begin
            send_item(mk(OP_STORE, 3'($urandom_range(0, JOINTS - 1)), pick_value(),
                         pick_value(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
            sent++;
          end
          if ($urandom_range(0, 99) < 6)
            send_item(mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), pick_value(),
                         pick_value(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
          send_item(mk(OP_TICK, 3'(j), pick_value(), pick_value(), 3'($urandom_range(0, 7)),
                       (j == JOINTS - 1) ^ ($urandom_range(0, 99) < 4)));
          sent++;
        end
      end
      settle();
    end

    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ajss_pkg.sv
hdl/ajss_front.sv
hdl/ajss_queue.sv
hdl/ajss_back.sv
hdl/arm_joint_setpoint_shaper.sv
verif/tb.sv
